[sv/rbba_pkg.sv]
package rbba_pkg;

   // Heap geometry
   localparam int HEAP_BLOCKS         = 28;
   localparam int BLOCK_BYTES         = 1024;
   localparam int FIRST_REGION_BLOCKS = 4;
   localparam int REGION_BLOCKS       = 8;
   localparam int MASK_BIT_OFFSET     = 4;
   localparam int MAX_RUN             = 15;

   localparam logic [31:0] HEAP_BASE = 32'h2000_1000;
   localparam logic [31:0] HEAP_END  = HEAP_BASE + 32'(HEAP_BLOCKS * BLOCK_BYTES);

   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int IDX_W       = $clog2(HEAP_BLOCKS);
   localparam int KW          = $clog2(HEAP_BLOCKS + 1);
   localparam int RUN_W       = 4;
   localparam int OWNER_W     = 8;
   localparam int SIZE_W      = 14;
   localparam int ADDR_W      = 32;
   localparam int MASK_W      = 32;
   localparam int STATUS_W    = 3;

   localparam logic [SIZE_W-1:0] MAX_REQUEST_BYTES = 14'h2000;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_BAD_ADDR  = 3'd3,
      ST_NOT_OWNER = 3'd4
   } status_type;

   // Datapath actions, one per control word
   typedef enum logic [3:0] {
      ACT_ACCEPT,
      ACT_NONE,
      ACT_SIZE,
      ACT_SCAN,
      ACT_MARK,
      ACT_ADDR,
      ACT_FIDX,
      ACT_FOWN,
      ACT_CLEAR,
      ACT_EMIT
   } act_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_FREE,
      COND_ERR,
      COND_SCAN_MORE,
      COND_MARK_MORE,
      COND_CLEAR_MORE,
      COND_RSP_FREE
   } cond_type;

   localparam int UPC_W = 4;

   // Program step addresses
   localparam logic [UPC_W-1:0] S_IDLE     = 4'd0;
   localparam logic [UPC_W-1:0] S_DISPATCH = 4'd1;
   localparam logic [UPC_W-1:0] S_SIZE     = 4'd2;
   localparam logic [UPC_W-1:0] S_SCAN     = 4'd3;
   localparam logic [UPC_W-1:0] S_HIT      = 4'd4;
   localparam logic [UPC_W-1:0] S_MARK     = 4'd5;
   localparam logic [UPC_W-1:0] S_ADDR     = 4'd6;
   localparam logic [UPC_W-1:0] S_FIDX     = 4'd7;
   localparam logic [UPC_W-1:0] S_FOWN     = 4'd8;
   localparam logic [UPC_W-1:0] S_FCLR     = 4'd9;
   localparam logic [UPC_W-1:0] S_EMIT     = 4'd10;
   localparam logic [UPC_W-1:0] S_HOLD     = 4'd11;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic no_req;
      logic is_free;
      logic err;
      logic scan_more;
      logic mark_more;
      logic clear_more;
      logic rsp_free;
   } cond_flags_type;

   // Jump taken when cond holds, else fall through to the next step
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] upc);
      uword_type w;
      unique case (upc)
         S_IDLE:     w = '{ACT_ACCEPT, COND_NO_REQ,     S_IDLE};
         S_DISPATCH: w = '{ACT_NONE,   COND_IS_FREE,    S_FIDX};
         S_SIZE:     w = '{ACT_SIZE,   COND_ERR,        S_EMIT};
         S_SCAN:     w = '{ACT_SCAN,   COND_SCAN_MORE,  S_SCAN};
         S_HIT:      w = '{ACT_NONE,   COND_ERR,        S_EMIT};
         S_MARK:     w = '{ACT_MARK,   COND_MARK_MORE,  S_MARK};
         S_ADDR:     w = '{ACT_ADDR,   COND_ALWAYS,     S_EMIT};
         S_FIDX:     w = '{ACT_FIDX,   COND_ERR,        S_EMIT};
         S_FOWN:     w = '{ACT_FOWN,   COND_ERR,        S_EMIT};
         S_FCLR:     w = '{ACT_CLEAR,  COND_CLEAR_MORE, S_FCLR};
         S_EMIT:     w = '{ACT_EMIT,   COND_RSP_FREE,   S_IDLE};
         S_HOLD:     w = '{ACT_NONE,   COND_ALWAYS,     S_EMIT};
         default:    w = '{ACT_NONE,   COND_ALWAYS,     S_IDLE};
      endcase
      return w;
   endfunction

   // Bit set for every block that opens a region
   function automatic logic [HEAP_BLOCKS-1:0] region_heads();
      logic [HEAP_BLOCKS-1:0] heads;
      heads = '0;
      for (int i = 0; i < HEAP_BLOCKS; i++) begin
         if (i == 0) begin
            heads[i] = 1'b1;
         end else if (i >= FIRST_REGION_BLOCKS &&
                      ((i - FIRST_REGION_BLOCKS) % REGION_BLOCKS) == 0) begin
            heads[i] = 1'b1;
         end
      end
      return heads;
   endfunction

   localparam logic [HEAP_BLOCKS-1:0] REGION_HEAD = region_heads();

   // Access mask bit of a block; bits at or above 32 are dropped
   function automatic logic [MASK_W-1:0] mask_bit(input logic [KW-1:0] idx);
      logic [KW:0] b;
      b = {1'b0, idx} + (KW+1)'(MASK_BIT_OFFSET);
      if (b >= (KW+1)'(MASK_W)) begin
         return '0;
      end
      return MASK_W'(1) << b;
   endfunction

endpackage

[sv/region_bounded_block_allocator.sv]
// Region-bounded first-fit block allocator, microcoded.
// Allocate: size check, first-fit block scan, run marking, address; free: address check,
//   owner check, block release. A failed check goes straight to the response step.
// One transaction at a time, plus any response stall; allocate with its block scan is the
//   longest. A new request is taken while the last response waits.
// Reset: synchronous, all blocks free, access mask zero, no response pending.
module region_bounded_block_allocator import rbba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // size_bytes[13:0], address[45:14],
                                              // requester[53:46], zero pad
   input  logic                   req_tuser,  // kind: 0 allocate, 1 free
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status[2:0], block_address[34:3],
                                              // access_mask[66:35], zero pad
);

   // Sequencer
   uword_type      uword;
   cond_flags_type flags;

   rbba_ucode u_ucode (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uword (uword)
   );

   // Latched request transaction
   logic                kind_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ADDR_W-1:0]   req_addr_ff;
   logic [OWNER_W-1:0]  who_ff;

   // Block table; owner and run length only matter while the block is used
   logic [HEAP_BLOCKS-1:0] used_ff, used_in;
   logic [OWNER_W-1:0]     owner_mem  [HEAP_BLOCKS];
   logic [RUN_W-1:0]       runlen_mem [HEAP_BLOCKS];
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic                   mem_we;

   // Working registers
   logic [KW-1:0]     k_ff, k_in;
   logic [KW-1:0]     start_ff, start_in;
   logic [RUN_W-1:0]  cnt_ff, cnt_in;
   logic [RUN_W-1:0]  blocks_ff, blocks_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] baddr_ff, baddr_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_free;
   logic              rsp_load;

   // Scratch
   logic [IDX_W-1:0]  kidx;
   logic [KW-1:0]     k_plus;
   logic [SIZE_W:0]   size_sum;
   logic [SIZE_W:0]   blk_wide;
   logic              used_k;
   logic              head_k;
   logic [RUN_W-1:0]  cnt_nx;
   logic [KW-1:0]     start_nx;
   logic              found;
   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] blk_off;
   logic              req_fire;

   assign req_tready = (uword.act == ACT_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign kidx       = k_ff[IDX_W-1:0];
   assign k_plus     = k_ff + KW'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (uword.act == ACT_EMIT) && rsp_free;

   always_comb begin
      used_in   = used_ff;
      mask_in   = mask_ff;
      mem_we    = 1'b0;
      k_in      = k_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      blocks_in = blocks_ff;
      status_in = status_ff;
      baddr_in  = baddr_ff;

      size_sum  = {1'b0, size_ff} + (SIZE_W+1)'(BLOCK_BYTES - 1);
      blk_wide  = size_sum >> BLOCK_SHIFT;

      // one step of the streaming first-fit scan: length of the free run
      // that ends at block k inside k's region
      used_k    = used_ff[kidx];
      head_k    = REGION_HEAD[kidx];
      cnt_nx    = used_k ? '0 : (head_k ? RUN_W'(1) : cnt_ff + RUN_W'(1));
      start_nx  = used_k ? k_plus : (head_k ? k_ff : start_ff);
      found     = !used_k && (cnt_nx == blocks_ff);

      offset    = req_addr_ff - HEAP_BASE;
      blk_off   = offset >> BLOCK_SHIFT;

      unique case (uword.act)
         ACT_SIZE: begin
            k_in      = '0;
            start_in  = '0;
            cnt_in    = '0;
            baddr_in  = '0;
            blocks_in = blk_wide[RUN_W-1:0];
            if (size_ff == '0 || size_ff > MAX_REQUEST_BYTES) begin
               status_in = ST_BAD_SIZE;
            end else if (blk_wide > (SIZE_W+1)'(MAX_RUN) ||
                         blk_wide > (SIZE_W+1)'(HEAP_BLOCKS)) begin
               status_in = ST_NO_SPACE;
            end else begin
               status_in = ST_OK;
            end
         end
         ACT_SCAN: begin
            start_in = start_nx;
            cnt_in   = cnt_nx;
            // on a hit, rewind k to the run start for marking
            k_in     = found ? start_nx : k_plus;
            if (!found && k_plus == KW'(HEAP_BLOCKS)) begin
               status_in = ST_NO_SPACE;
            end
         end
         ACT_MARK: begin
            used_in[kidx] = 1'b1;
            mem_we        = 1'b1;
            mask_in       = mask_ff | mask_bit(k_ff);
            k_in          = k_plus;
            cnt_in        = cnt_ff - RUN_W'(1);
         end
         ACT_ADDR: begin
            baddr_in = HEAP_BASE + (ADDR_W'(start_ff) << BLOCK_SHIFT);
         end
         ACT_FIDX: begin
            baddr_in = '0;
            k_in     = KW'(blk_off);
            if (blk_off >= ADDR_W'(HEAP_BLOCKS)) begin
               status_in = ST_BAD_ADDR;
            end else begin
               status_in = ST_OK;
            end
         end
         ACT_FOWN: begin
            cnt_in = runlen_mem[kidx];
            if (owner_mem[kidx] != who_ff || !used_ff[kidx]) begin
               status_in = ST_NOT_OWNER;
            end
         end
         ACT_CLEAR: begin
            if (cnt_ff != '0) begin
               used_in[kidx] = 1'b0;
               mask_in       = mask_ff & ~mask_bit(k_ff);
            end
            k_in   = k_plus;
            cnt_in = cnt_ff - RUN_W'(1);
         end
         default: begin
         end
      endcase

      flags.no_req     = !req_fire;
      flags.is_free    = kind_ff;
      flags.err        = (status_in != ST_OK);
      flags.scan_more  = !found && (k_plus < KW'(HEAP_BLOCKS));
      flags.mark_more  = (cnt_ff != RUN_W'(1));
      flags.clear_more = (cnt_ff > RUN_W'(1)) && (k_plus < KW'(HEAP_BLOCKS));
      flags.rsp_free   = rsp_free;

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_tuser;
         size_ff     <= req_tdata[SIZE_W-1:0];
         req_addr_ff <= req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
         who_ff      <= req_tdata[SIZE_W+ADDR_W+OWNER_W-1:SIZE_W+ADDR_W];
      end
      k_ff      <= k_in;
      start_ff  <= start_in;
      cnt_ff    <= cnt_in;
      blocks_ff <= blocks_in;
      status_ff <= status_in;
      baddr_ff  <= baddr_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= baddr_ff;
         rsp_mask_ff   <= mask_ff;
      end
   end

   // Owner and run length table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[kidx]  <= who_ff;
         runlen_mem[kidx] <= blocks_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - STATUS_W - ADDR_W - MASK_W)'(0),
                        rsp_mask_ff, rsp_addr_ff, rsp_status_ff};

endmodule

[sv/rbba_ucode.sv]
module rbba_ucode import rbba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cond_flags_type flags,
   output uword_type      uword
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             hit;

   assign uword = ucode_rom(upc_ff);

   always_comb begin
      unique case (uword.cond)
         COND_ALWAYS:     hit = 1'b1;
         COND_NO_REQ:     hit = flags.no_req;
         COND_IS_FREE:    hit = flags.is_free;
         COND_ERR:        hit = flags.err;
         COND_SCAN_MORE:  hit = flags.scan_more;
         COND_MARK_MORE:  hit = flags.mark_more;
         COND_CLEAR_MORE: hit = flags.clear_more;
         COND_RSP_FREE:   hit = flags.rsp_free;
         default:         hit = 1'b1;
      endcase
      upc_in = hit ? uword.target : upc_ff + UPC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[sv/rbba_checker.sv]
module rbba_checker import rbba_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   baddr;

   assign status = rsp_tdata[STATUS_W-1:0];
   assign baddr  = rsp_tdata[STATUS_W+ADDR_W-1:STATUS_W];

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status <= ST_NOT_OWNER)
      else $error("undefined status code");

   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ST_OK |-> baddr == '0)
      else $error("failed transaction returned an address");

   a_addr_in_heap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_OK && baddr != '0 |->
         baddr >= HEAP_BASE && baddr < HEAP_END && baddr[BLOCK_SHIFT-1:0] == '0)
      else $error("allocated address outside heap or unaligned");

   // one transaction in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

bind region_bounded_block_allocator rbba_checker u_checker (.*);

[tb/tb_region_bounded_block_allocator.sv]
`timescale 1ns / 1ps

module tb_region_bounded_block_allocator;
   import rbba_pkg::*;

   // request kinds carried on req_tuser
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam int RANDOM_ITEMS  = 1450;
   localparam int N_DIRECTED    = 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // margin past the worst-case allocate latency
   localparam int SETTLE_CYCLES = 60;
   // long receiver hold-off so the block backs up and drops req_tready
   localparam int LONG_HOLD     = 300;

   // handshake idling phases over the random part
   typedef enum int {
      PH_NONE,
      PH_SENDER,
      PH_RECEIVER,
      PH_BOTH
   } idle_phase_type;

   // one response transaction, field by field
   typedef struct packed {
      status_type  status;
      logic [31:0] block_address;
      logic [31:0] access_mask;
   } alloc_result_type;

   // expectation typed into the directed table; typed = 0 means use the predictor
   typedef struct packed {
      logic             typed;
      alloc_result_type result;
   } fixed_result_type;

   typedef struct packed {
      logic             kind;
      logic [13:0]      size;
      logic [31:0]      addr;
      logic [7:0]       who;
      fixed_result_type fixed;
   } stim_row_type;

   localparam fixed_result_type USE_PREDICTOR   = '0;
   localparam fixed_result_type EMPTY_BAD_SIZE  = '{1'b1, '{ST_BAD_SIZE, 32'h0, 32'h0}};
   localparam fixed_result_type EMPTY_BAD_ADDR  = '{1'b1, '{ST_BAD_ADDR, 32'h0, 32'h0}};
   localparam fixed_result_type EMPTY_NOT_OWNER = '{1'b1, '{ST_NOT_OWNER, 32'h0, 32'h0}};
   // first allocate on an empty heap: block 0, mask bit 4
   localparam fixed_result_type FIRST_BLOCK_OK  =
      '{1'b1, '{ST_OK, HEAP_BASE, 32'h0000_0010}};

   // DUT ports; every input has a known value from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // size_bytes, address, requester, pad
   logic                   req_tuser  = 1'b0; // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // status, block_address, access_mask, pad

   // predicted heap state, updated at each accepted request transaction
   logic        heap_used  [HEAP_BLOCKS];
   logic [7:0]  heap_owner [HEAP_BLOCKS];
   logic [3:0]  heap_len   [HEAP_BLOCKS];
   logic [31:0] heap_mask;

   alloc_result_type result_queue [$];   // responses still owed by the block, oldest first
   fixed_result_type fixed_queue  [$];   // table expectations, one per request in flight

   int             mismatch_count = 0;
   int             cycle_count    = 0;
   idle_phase_type idle_phase     = PH_NONE;
   logic           hold_trigger   = 1'b0;
   logic           hold_started   = 1'b0;
   int             hold_left      = 0;

   region_bounded_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // region number: blocks 0..3 are region 0, then groups of eight
   function automatic int region_of(input int idx);
      if (idx < FIRST_REGION_BLOCKS) begin
         return 0;
      end
      return (idx - FIRST_REGION_BLOCKS) / REGION_BLOCKS + 1;
   endfunction

   // Heap model: first-fit allocate inside one region, or free from the
   // addressed block for that block's recorded run length.
   task automatic predict_allocator(input logic kind, input logic [13:0] size,
                                    input logic [31:0] addr, input logic [7:0] who,
                                    output alloc_result_type res);
      int          nblk;
      int          start;
      int          k;
      int          len;
      logic        fits;
      logic        found;
      logic [31:0] offset;
      logic [31:0] idx;
      res.status        = ST_OK;
      res.block_address = '0;
      if (kind == KIND_ALLOC) begin
         if (size == 0 || size > MAX_REQUEST_BYTES) begin
            res.status = ST_BAD_SIZE;
         end else begin
            nblk  = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            found = 1'b0;
            if (nblk <= MAX_RUN && nblk <= HEAP_BLOCKS) begin
               for (start = 0; start + nblk <= HEAP_BLOCKS && !found; start++) begin
                  fits = 1'b1;
                  for (k = start; k < start + nblk; k++) begin
                     if (heap_used[k] || region_of(k) != region_of(start)) begin
                        fits = 1'b0;
                     end
                  end
                  if (fits) begin
                     found = 1'b1;
                     for (k = start; k < start + nblk; k++) begin
                        heap_used[k]  = 1'b1;
                        heap_owner[k] = who;
                        heap_len[k]   = 4'(nblk);
                        if (k + MASK_BIT_OFFSET < MASK_W) begin
                           heap_mask[k + MASK_BIT_OFFSET] = 1'b1;
                        end
                     end
                     res.block_address = HEAP_BASE + 32'(start * BLOCK_BYTES);
                  end
               end
            end
            if (!found) begin
               res.status = ST_NO_SPACE;
            end
         end
      end else begin
         // addresses below the heap wrap to a huge offset
         offset = addr - HEAP_BASE;
         idx    = offset / 32'(BLOCK_BYTES);
         if (idx >= 32'(HEAP_BLOCKS)) begin
            res.status = ST_BAD_ADDR;
         end else if (heap_owner[idx] != who || !heap_used[idx]) begin
            res.status = ST_NOT_OWNER;
         end else begin
            // run length counts from the addressed block, clipped at heap end
            len = int'(heap_len[idx]);
            for (k = int'(idx); k < int'(idx) + len && k < HEAP_BLOCKS; k++) begin
               heap_used[k]  = 1'b0;
               heap_owner[k] = 8'h00;
               heap_len[k]   = 4'd0;
               if (k + MASK_BIT_OFFSET < MASK_W) begin
                  heap_mask[k + MASK_BIT_OFFSET] = 1'b0;
               end
            end
         end
      end
      res.access_mask = heap_mask;
   endtask

   // Random request: mostly allocates and frees of live runs by their owner,
   // with some noise (bad sizes, stray addresses, wrong owners).
   task automatic make_random_item(output stim_row_type row);
      int mix;
      int j;
      int head;
      int tries;
      int found;
      int pick;
      row.kind  = KIND_ALLOC;
      row.size  = 14'($urandom);
      row.addr  = $urandom;
      row.who   = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      row.fixed = USE_PREDICTOR;
      mix   = $urandom_range(99);
      found = -1;
      if (mix >= 45 && mix < 85) begin
         j = $urandom_range(HEAP_BLOCKS - 1);
         for (tries = 0; tries < HEAP_BLOCKS && found < 0; tries++) begin
            if (heap_used[j]) begin
               found = j;
            end else begin
               j = (j + 1) % HEAP_BLOCKS;
            end
         end
      end
      if (found >= 0) begin
         // walk back to the likely run head; now and then free from inside
         head = found;
         if ($urandom_range(9) != 0) begin
            while (head > 0 && heap_used[head-1] &&
                   heap_owner[head-1] == heap_owner[found] &&
                   heap_len[head-1] == heap_len[found] &&
                   region_of(head-1) == region_of(found) &&
                   found - head + 1 < int'(heap_len[found])) begin
               head--;
            end
         end
         row.kind = KIND_FREE;
         row.who  = heap_owner[found];
         row.addr = HEAP_BASE + 32'(head * BLOCK_BYTES);
         if ($urandom_range(3) == 0) begin
            row.addr = row.addr + 32'($urandom_range(BLOCK_BYTES - 1));
         end
      end else if (mix >= 85) begin
         pick = $urandom_range(2);
         case (pick)
            0: begin
               row.size = $urandom_range(1) ? 14'd0 : 14'($urandom_range(16383, 8193));
            end
            1: begin
               row.kind = KIND_FREE;
            end
            default: begin
               row.kind = KIND_FREE;
               row.addr = HEAP_BASE + 32'($urandom_range(HEAP_BLOCKS * BLOCK_BYTES - 1));
               row.who  = 8'($urandom_range(255));
            end
         endcase
      end else begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            row.size = 14'($urandom_range(2048, 1));
         end else if (pick < 80) begin
            row.size = 14'($urandom_range(8192, 2049));
         end else begin
            row.size = 14'($urandom_range(8, 1) * BLOCK_BYTES);
         end
      end
   endtask

   // Offer one request transaction and hold it until accepted, then idle
   // the sender for a random stretch according to the phase.
   task automatic send_item(input stim_row_type row);
      int idle_pct;
      fixed_queue.push_back(row.fixed);
      req_tvalid <= 1'b1;
      req_tuser  <= row.kind;
      req_tdata  <= {2'b00, row.who, row.addr, row.size};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      idle_pct = (idle_phase == PH_SENDER) ? 48 : (idle_phase == PH_BOTH) ? 8 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stimulus: reset, directed table, random stream, drain
   initial begin
      stim_row_type directed_tab [N_DIRECTED];
      stim_row_type item;
      int           i;
      directed_tab = '{
         // empty heap: size extremes, addresses outside the heap, unallocated block
         '{KIND_ALLOC, 14'd0,     32'h0000_0000,        8'h00, EMPTY_BAD_SIZE},
         '{KIND_ALLOC, 14'd8193,  32'hFFFF_FFFF,        8'h01, EMPTY_BAD_SIZE},
         '{KIND_ALLOC, 14'd16383, 32'h0000_0000,        8'hFF, EMPTY_BAD_SIZE},
         '{KIND_FREE,  14'd16383, 32'h0000_0000,        8'h00, EMPTY_BAD_ADDR},
         '{KIND_FREE,  14'd0,     32'hFFFF_FFFF,        8'hFF, EMPTY_BAD_ADDR},
         '{KIND_FREE,  14'd0,     HEAP_END,             8'h00, EMPTY_BAD_ADDR},
         '{KIND_FREE,  14'd0,     HEAP_BASE - 32'd1,    8'h00, EMPTY_BAD_ADDR},
         '{KIND_FREE,  14'd0,     HEAP_BASE,            8'h00, EMPTY_NOT_OWNER},
         '{KIND_ALLOC, 14'd1,     32'h0000_0000,        8'h11, FIRST_BLOCK_OK},
         // largest request, then runs that must skip a full region
         '{KIND_ALLOC, 14'd8192,  32'hFFFF_FFFF,        8'hFF, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd4096,  32'h0000_0000,        8'h22, USE_PREDICTOR},
         // wrong owner, then unaligned free by the owner
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h1000, 8'h11, USE_PREDICTOR},
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h1005, 8'hFF, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd3072,  32'h0000_0000,        8'h33, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd8192,  32'h0000_0000,        8'h44, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd8192,  32'h0000_0000,        8'h55, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd1024,  32'h0000_0000,        8'h66, USE_PREDICTOR},
         // free from inside a run spills into the following run
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h3400, 8'h22, USE_PREDICTOR},
         // free from inside the last run: release clipped at heap end
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h6000, 8'h55, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd8192,  32'h0000_0000,        8'h77, USE_PREDICTOR},
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h3400, 8'h22, USE_PREDICTOR},
         '{KIND_FREE,  14'd0,     HEAP_END - 32'd1,     8'h00, USE_PREDICTOR},
         '{KIND_ALLOC, 14'd7169,  32'h0000_0000,        8'h88, USE_PREDICTOR},
         '{KIND_FREE,  14'd0,     HEAP_BASE + 32'h0400, 8'h33, USE_PREDICTOR}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < N_DIRECTED; i++) begin
         send_item(directed_tab[i]);
      end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         idle_phase = idle_phase_type'((i * 4) / RANDOM_ITEMS);
         // long hold-off early on, while the sender keeps offering
         if (i == RANDOM_ITEMS / 8) begin
            hold_trigger = 1'b1;
         end
         make_random_item(item);
         send_item(item);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (result_queue.size() != 0) begin
         @(posedge clock);
      end
      // catch any stray response after the last one owed
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && result_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // response side: random stalls per phase, plus one long counted hold-off
   always @(posedge clock) begin
      if (hold_trigger && !hold_started) begin
         hold_started <= 1'b1;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_phase == PH_RECEIVER) begin
         rsp_tready <= ($urandom_range(99) >= 48);
      end else if (idle_phase == PH_BOTH) begin
         rsp_tready <= ($urandom_range(99) >= 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted request transaction, compare each
   // accepted response transaction with the oldest expectation.
   always @(posedge clock) begin : monitor
      alloc_result_type predicted;
      alloc_result_type want;
      fixed_result_type fixed;
      int               k;
      if (reset) begin
         for (k = 0; k < HEAP_BLOCKS; k++) begin
            heap_used[k]  = 1'b0;
            heap_owner[k] = 8'h00;
            heap_len[k]   = 4'd0;
         end
         heap_mask = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               $display("%0t ns: response with none expected, actual %h",
                        $time, rsp_tdata[66:0]);
               mismatch_count++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $display("%0t ns: status expected %0d actual %0d",
                           $time, want.status, rsp_tdata[2:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[34:3] !== want.block_address) begin
                  $display("%0t ns: block_address expected %h actual %h",
                           $time, want.block_address, rsp_tdata[34:3]);
                  mismatch_count++;
               end
               if (rsp_tdata[66:35] !== want.access_mask) begin
                  $display("%0t ns: access_mask expected %h actual %h",
                           $time, want.access_mask, rsp_tdata[66:35]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_allocator(req_tuser, req_tdata[13:0], req_tdata[45:14],
                              req_tdata[53:46], predicted);
            fixed = (fixed_queue.size() != 0) ? fixed_queue.pop_front() : USE_PREDICTOR;
            result_queue.push_back(fixed.typed ? fixed.result : predicted);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d responses outstanding", $time, result_queue.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
